// ----- hw/rtl/iee_pkg.sv -----
`timescale 1ns / 1ps
// Package: shared types, codes and constants for the infix expression evaluator.
package iee_pkg;

  localparam int StackDepth = 16;
  localparam int PtrW = $clog2(StackDepth);
  localparam int CntW = $clog2(StackDepth + 1);
  localparam int DataW = 16;

  typedef enum logic [2:0] {
    ACT_BEGIN   = 3'd0,
    ACT_OPERAND = 3'd1,
    ACT_OPER    = 3'd2,
    ACT_LPAREN  = 3'd3,
    ACT_RPAREN  = 3'd4,
    ACT_FINISH  = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    OP_ORNOT = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3,
    OP_DIV = 4'd4, OP_MOD = 4'd5, OP_SHR = 4'd6, OP_SHL = 4'd7,
    OP_AND = 4'd8, OP_XOR = 4'd9, OP_OR = 4'd10, OP_PAREN = 4'd15
  } opcode_t;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_OP_UNDER = 4'd1, ST_VAL_UNDER = 4'd2, ST_OP_OVER = 4'd3,
    ST_VAL_OVER = 4'd4, ST_ZERO_DIV = 4'd5, ST_STRAY_LP = 4'd6,
    ST_STRAY_RP = 4'd7, ST_LEFTOVER = 4'd8
  } status_t;

  localparam logic [1:0] CLS_UNRES  = 2'd0;
  localparam logic [1:0] CLS_RELOC  = 2'd1;
  localparam logic [1:0] CLS_STATIC = 2'd2;
  localparam logic [1:0] MODE_RELOC = 2'd1;
  localparam logic [1:0] MODE_FORCE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CHECK, S_POP_OP, S_RD_B, S_RD_A, S_EXEC,
    S_DIV, S_PUSH_R, S_SCAN, S_RESULT, S_RD_FINAL, S_OUT
  } state_t;

  // datapath commands from the controller
  typedef struct packed {
    logic load_item;
    logic do_begin;
    logic push_val;
    logic push_op;
    logic push_paren;
    logic pop_op;
    logic drop_op;
    logic read_b;
    logic read_a;
    logic exec;
    logic div_start;
    logic push_res;
    logic scan_start;
    logic scan_step;
    logic read_final;
    logic set_err;
    logic [3:0] err_code;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] opc;
    logic       opc_valid;
    logic [CntW-1:0] vcnt;
    logic [CntW-1:0] ocnt;
    logic [3:0] top_op;
    logic [3:0] cur_op;
    logic       prec_le;
    logic       err;
    logic       div_zero;
    logic       div_done;
    logic       scan_done;
    logic       scan_found;
    logic       pass;
  } sts_t;

  function automatic logic [2:0] prec_of(input logic [3:0] code);
    logic [2:0] p;
    case (code)
      OP_ORNOT: p = 3'd1;
      OP_ADD, OP_SUB: p = 3'd2;
      OP_MUL, OP_DIV, OP_MOD: p = 3'd3;
      OP_SHR, OP_SHL: p = 3'd4;
      OP_AND: p = 3'd5;
      OP_XOR: p = 3'd6;
      OP_OR: p = 3'd7;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/iee_if.sv -----
`timescale 1ns / 1ps
// Interfaces: input and output word channels with valid/ready handshake.
interface iee_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [15:0] operand;
  logic [1:0] operand_class;
  logic [3:0] operator_code;
  logic [1:0] start_mode;
  modport source (output valid, action, operand, operand_class, operator_code, start_mode,
                  input ready);
  modport sink (input valid, action, operand, operand_class, operator_code, start_mode,
                output ready);
endinterface

interface iee_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [15:0] result;
  logic [1:0] result_class;
  logic       done_res;
  modport source (output valid, status, result, result_class, done_res, input ready);
  modport sink (input valid, status, result, result_class, done_res, output ready);
endinterface

// ----- hw/rtl/iee_divider.sv -----
`timescale 1ns / 1ps
// Divider: 16-bit restoring divide, one quotient bit per cycle.
module iee_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [15:0] quotient,
  output logic [15:0] remainder
);
  logic [4:0]  count;
  logic [15:0] den;
  logic [16:0] trial;

  assign trial = {remainder, quotient[15]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 5'd16;
        quotient <= dividend;
        remainder <= '0;
        den <= divisor;
      end else if (busy) begin
        if (!trial[16]) begin
          remainder <= trial[15:0];
          quotient <= {quotient[14:0], 1'b1};
        end else begin
          remainder <= {remainder[14:0], quotient[15]};
          quotient <= {quotient[14:0], 1'b0};
        end
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- hw/rtl/iee_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: stacks, counts, class tracking, ALU with divider and output register.
module iee_datapath (
  input  logic           clk,
  input  logic           rst,
  input  logic           pass_number,
  input  logic [2:0]     action,
  input  logic [15:0]    operand,
  input  logic [1:0]     operand_class,
  input  logic [3:0]     operator_code,
  input  logic [1:0]     start_mode,
  input  iee_pkg::cmd_t  cmd,
  output iee_pkg::sts_t  sts,
  output logic [3:0]     status,
  output logic [15:0]    result,
  output logic [1:0]     result_class,
  output logic           done_res
);
  localparam int PW = iee_pkg::PtrW;
  localparam int CW = iee_pkg::CntW;

  logic [15:0] vmem [iee_pkg::StackDepth];
  logic [3:0]  omem [iee_pkg::StackDepth];

  logic [2:0]  act_r;
  logic [15:0] opnd_r;
  logic [1:0]  ocls_r;
  logic [3:0]  opc_r;
  logic [1:0]  smode_r;
  logic [CW-1:0] vcnt, ocnt;
  logic [1:0]  rclass;
  logic        force_st;
  logic [3:0]  err;
  logic        pass;
  logic [3:0]  top_op, cur_op;
  logic [15:0] vrd, a_r, b_r, alu_r;
  logic [CW-1:0] scan_i;
  logic        scan_found, scan_busy;
  logic        div_busy, div_done;
  logic [15:0] quo, rem;
  logic [1:0]  ocls_eff;
  logic [31:0] prod;
  logic [15:0] alu_next;

  assign ocls_eff = (ocls_r == 2'd3) ? iee_pkg::CLS_STATIC : ocls_r;
  assign prod = a_r * b_r;

  iee_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(a_r), .divisor(b_r),
    .busy(div_busy), .done(div_done), .quotient(quo), .remainder(rem)
  );

  always_comb begin
    case (cur_op)
      iee_pkg::OP_ORNOT: alu_next = a_r | ~b_r;
      iee_pkg::OP_ADD:   alu_next = a_r + b_r;
      iee_pkg::OP_SUB:   alu_next = a_r - b_r;
      iee_pkg::OP_MUL:   alu_next = prod[15:0];
      iee_pkg::OP_SHR:   alu_next = (b_r >= 16'd16) ? 16'd0 : (a_r >> b_r[3:0]);
      iee_pkg::OP_SHL:   alu_next = (b_r >= 16'd16) ? 16'd0 : (a_r << b_r[3:0]);
      iee_pkg::OP_AND:   alu_next = a_r & b_r;
      iee_pkg::OP_XOR:   alu_next = a_r ^ b_r;
      iee_pkg::OP_OR:    alu_next = a_r | b_r;
      default:           alu_next = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r <= action;
      opnd_r <= operand;
      ocls_r <= operand_class;
      opc_r <= operator_code;
      smode_r <= start_mode;
      pass <= pass_number;
    end
    if (cmd.push_val) vmem[vcnt[PW-1:0]] <= opnd_r;
    if (cmd.push_res) vmem[vcnt[PW-1:0]] <= alu_r;
    if (cmd.push_op) omem[ocnt[PW-1:0]] <= opc_r;
    if (cmd.push_paren) omem[ocnt[PW-1:0]] <= iee_pkg::OP_PAREN;
    top_op <= omem[ocnt[PW-1:0] - PW'(1)];
    if (cmd.pop_op) cur_op <= omem[ocnt[PW-1:0] - PW'(1)];
    if (cmd.read_b) vrd <= vmem[vcnt[PW-1:0] - PW'(1)];
    if (cmd.read_a) vrd <= vmem[vcnt[PW-1:0] - PW'(2)];
    if (cmd.read_final) vrd <= vmem[0];
    if (cmd.scan_step) scan_found <= scan_found | (omem[scan_i[PW-1:0]] == iee_pkg::OP_PAREN);
    if (cmd.scan_start) scan_found <= 1'b0;
    if (cmd.load_out) begin
      status <= err;
      done_res <= (act_r == iee_pkg::ACT_FINISH);
      if (act_r == iee_pkg::ACT_FINISH) begin
        result <= (err == iee_pkg::ST_OK) ? vrd : 16'd0;
        result_class <= (err != iee_pkg::ST_OK) ? iee_pkg::CLS_UNRES :
                        (force_st && rclass != iee_pkg::CLS_UNRES) ? iee_pkg::CLS_STATIC :
                        rclass;
      end else begin
        result <= 16'd0;
        result_class <= rclass;
      end
    end
  end

  // a holds the left operand; the alu result is captured through the alu_load register after operands settle
  logic alu_load;
  always_ff @(posedge clk) begin
    if (cmd.read_a) b_r <= vrd;
    if (cmd.exec) a_r <= vrd;
    alu_load <= cmd.exec;
    if (div_done) alu_r <= (cur_op == iee_pkg::OP_DIV) ? quo : rem;
    else if (alu_load && !div_busy) alu_r <= alu_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt <= '0;
      ocnt <= '0;
      rclass <= iee_pkg::CLS_STATIC;
      force_st <= 1'b0;
      err <= iee_pkg::ST_OK;
      scan_i <= '0;
      scan_busy <= 1'b0;
    end else begin
      if (cmd.do_begin) begin
        vcnt <= '0;
        ocnt <= '0;
        err <= iee_pkg::ST_OK;
        force_st <= (smode_r == iee_pkg::MODE_FORCE);
        rclass <= (smode_r == iee_pkg::MODE_RELOC) ? iee_pkg::CLS_RELOC : iee_pkg::CLS_STATIC;
      end
      if (cmd.push_val) begin
        vcnt <= vcnt + CW'(1);
      end
      // class follows every operand taken while no error is set, even one that overflows the stack
      if (cmd.push_val || (cmd.set_err && cmd.err_code == iee_pkg::ST_VAL_OVER)) begin
        if (ocls_eff < rclass) rclass <= ocls_eff;
      end
      if (cmd.push_op || cmd.push_paren) ocnt <= ocnt + CW'(1);
      if (cmd.pop_op || cmd.drop_op) ocnt <= ocnt - CW'(1);
      if (cmd.exec) vcnt <= vcnt - CW'(2);
      if (cmd.push_res) vcnt <= vcnt + CW'(1);
      if (cmd.set_err) err <= cmd.err_code;
      if (cmd.scan_start) begin
        scan_i <= '0;
        scan_busy <= 1'b1;
      end else if (cmd.scan_step) begin
        scan_i <= scan_i + CW'(1);
      end
    end
  end

  assign sts.action = act_r;
  assign sts.opc = opc_r;
  assign sts.opc_valid = (opc_r <= iee_pkg::OP_OR);
  assign sts.vcnt = vcnt;
  assign sts.ocnt = ocnt;
  assign sts.top_op = top_op;
  assign sts.cur_op = cur_op;
  assign sts.prec_le = (iee_pkg::prec_of(opc_r) <= iee_pkg::prec_of(top_op));
  assign sts.err = (err != iee_pkg::ST_OK);
  assign sts.div_zero = (b_r == 16'd0);
  assign sts.div_done = div_done;
  assign sts.scan_done = scan_busy && (scan_i >= ocnt);
  assign sts.scan_found = scan_found;
  assign sts.pass = pass;
endmodule

// ----- hw/rtl/iee_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: state machine that sequences stack operations for each word.
module iee_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  iee_pkg::sts_t sts,
  output iee_pkg::cmd_t cmd
);
  localparam logic [1:0] M_OPER   = 2'd0;
  localparam logic [1:0] M_RPAREN = 2'd1;
  localparam logic [1:0] M_FINISH = 2'd2;

  iee_pkg::state_t state, state_next;
  logic [1:0] mode, mode_next;
  logic [1:0] wait_cnt, wait_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iee_pkg::S_IDLE;
      mode <= M_OPER;
      wait_cnt <= '0;
    end else begin
      state <= state_next;
      mode <= mode_next;
      wait_cnt <= wait_cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    mode_next = mode;
    wait_cnt_next = wait_cnt;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      iee_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = iee_pkg::S_DISPATCH;
        end
      end
      iee_pkg::S_DISPATCH: begin
        state_next = iee_pkg::S_RESULT;
        if (sts.action == iee_pkg::ACT_BEGIN) begin
          cmd.do_begin = 1'b1;
        end else if (!sts.err) begin
          case (sts.action)
            iee_pkg::ACT_OPERAND: begin
              if (sts.vcnt >= iee_pkg::CntW'(iee_pkg::StackDepth)) begin
                cmd.set_err = 1'b1;
                cmd.err_code = iee_pkg::ST_VAL_OVER;
              end else begin
                cmd.push_val = 1'b1;
              end
            end
            iee_pkg::ACT_OPER: begin
              if (sts.opc_valid) begin
                mode_next = M_OPER;
                state_next = iee_pkg::S_CHECK;
              end
            end
            iee_pkg::ACT_LPAREN: begin
              if (sts.ocnt >= iee_pkg::CntW'(iee_pkg::StackDepth)) begin
                cmd.set_err = 1'b1;
                cmd.err_code = iee_pkg::ST_OP_OVER;
              end else begin
                cmd.push_paren = 1'b1;
              end
            end
            iee_pkg::ACT_RPAREN: begin
              mode_next = M_RPAREN;
              cmd.scan_start = 1'b1;
              state_next = iee_pkg::S_SCAN;
            end
            iee_pkg::ACT_FINISH: begin
              mode_next = M_FINISH;
              state_next = iee_pkg::S_CHECK;
            end
            default: state_next = iee_pkg::S_RESULT;
          endcase
        end
      end
      iee_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          if (sts.scan_found) begin
            state_next = iee_pkg::S_CHECK;
          end else begin
            cmd.set_err = 1'b1;
            cmd.err_code = iee_pkg::ST_STRAY_RP;
            state_next = iee_pkg::S_RESULT;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      // top_op is registered from the count, so it settles in the cycle after the count changes
      iee_pkg::S_CHECK: begin
        if (wait_cnt == 2'd0) begin
          wait_cnt_next = 2'd1;
        end else begin
          wait_cnt_next = 2'd0;
          state_next = iee_pkg::S_RESULT;
          case (mode)
            M_OPER: begin
              if (sts.ocnt != '0 && sts.prec_le) begin
                state_next = iee_pkg::S_POP_OP;
              end else if (sts.ocnt >= iee_pkg::CntW'(iee_pkg::StackDepth)) begin
                cmd.set_err = 1'b1;
                cmd.err_code = iee_pkg::ST_OP_OVER;
              end else begin
                cmd.push_op = 1'b1;
              end
            end
            M_RPAREN: begin
              if (sts.ocnt == '0) begin
                state_next = iee_pkg::S_RESULT;
              end else if (sts.top_op == iee_pkg::OP_PAREN) begin
                cmd.drop_op = 1'b1;
              end else begin
                state_next = iee_pkg::S_POP_OP;
              end
            end
            default: begin
              if (sts.ocnt != '0) begin
                state_next = iee_pkg::S_POP_OP;
              end else if (sts.vcnt == '0) begin
                cmd.set_err = 1'b1;
                cmd.err_code = iee_pkg::ST_VAL_UNDER;
              end else if (sts.vcnt != iee_pkg::CntW'(1)) begin
                cmd.set_err = 1'b1;
                cmd.err_code = iee_pkg::ST_LEFTOVER;
              end else begin
                cmd.read_final = 1'b1;
                state_next = iee_pkg::S_RD_FINAL;
              end
            end
          endcase
        end
      end
      iee_pkg::S_POP_OP: begin
        cmd.pop_op = 1'b1;
        state_next = iee_pkg::S_RD_B;
      end
      iee_pkg::S_RD_B: begin
        if (sts.vcnt < iee_pkg::CntW'(2)) begin
          cmd.set_err = 1'b1;
          cmd.err_code = iee_pkg::ST_VAL_UNDER;
          state_next = iee_pkg::S_RESULT;
        end else if (sts.cur_op == iee_pkg::OP_PAREN) begin
          cmd.set_err = 1'b1;
          cmd.err_code = iee_pkg::ST_STRAY_LP;
          state_next = iee_pkg::S_RESULT;
        end else begin
          cmd.read_b = 1'b1;
          state_next = iee_pkg::S_RD_A;
        end
      end
      iee_pkg::S_RD_A: begin
        cmd.read_a = 1'b1;
        state_next = iee_pkg::S_EXEC;
      end
      iee_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = iee_pkg::S_DIV;
      end
      iee_pkg::S_DIV: begin
        if (sts.cur_op == iee_pkg::OP_DIV || sts.cur_op == iee_pkg::OP_MOD) begin
          if (wait_cnt == 2'd0) begin
            if (sts.div_zero) begin
              if (sts.pass) begin
                cmd.set_err = 1'b1;
                cmd.err_code = iee_pkg::ST_ZERO_DIV;
                state_next = iee_pkg::S_RESULT;
              end else begin
                state_next = iee_pkg::S_PUSH_R;
              end
            end else begin
              cmd.div_start = 1'b1;
              wait_cnt_next = 2'd1;
            end
          end else if (sts.div_done) begin
            wait_cnt_next = 2'd0;
            state_next = iee_pkg::S_PUSH_R;
          end
        end else begin
          state_next = iee_pkg::S_PUSH_R;
        end
      end
      iee_pkg::S_PUSH_R: begin
        cmd.push_res = 1'b1;
        state_next = iee_pkg::S_CHECK;
      end
      iee_pkg::S_RD_FINAL: begin
        state_next = iee_pkg::S_RESULT;
      end
      iee_pkg::S_RESULT: begin
        cmd.load_out = 1'b1;
        state_next = iee_pkg::S_OUT;
      end
      iee_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = iee_pkg::S_IDLE;
      end
      default: state_next = iee_pkg::S_IDLE;
    endcase
  end
endmodule

// ----- hw/rtl/infix_expression_evaluator_top.sv -----
`timescale 1ns / 1ps
// Top level: infix expression evaluator with operator and value stacks.
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    action, operand, operand_class, operator_code, start_mode
//  out_ch    out  valid/ready    status, result, result_class, done_res
//  cfg       in   pass_we        pass_wdata (pass number)
//
// One word at a time: begin, operand and left paren words pass dispatch and result; an
// operator applies each stacked operator it pops (pop, read b, read a, exec, push), div/mod through the
// bit-serial divider. A right paren first scans the operator stack, one entry a cycle.
// Reset (rst, synchronous) clears counts, class and error. Input is held off until the
// result word has been taken.
module infix_expression_evaluator_top (
  input logic clk,
  input logic rst,
  input logic pass_we,
  input logic pass_wdata,
  iee_in_if.sink in_ch,
  iee_out_if.source out_ch
);
  iee_pkg::cmd_t cmd;
  iee_pkg::sts_t sts;
  logic pass_number;

  always_ff @(posedge clk) begin
    if (rst) pass_number <= 1'b0;
    else if (pass_we) pass_number <= pass_wdata;
  end

  iee_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd)
  );

  iee_datapath u_dp (
    .clk(clk), .rst(rst), .pass_number(pass_number),
    .action(in_ch.action), .operand(in_ch.operand), .operand_class(in_ch.operand_class),
    .operator_code(in_ch.operator_code), .start_mode(in_ch.start_mode),
    .cmd(cmd), .sts(sts),
    .status(out_ch.status), .result(out_ch.result), .result_class(out_ch.result_class),
    .done_res(out_ch.done_res)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("input taken while result pending");
  a_vcnt_range: assert property (@(posedge clk) disable iff (rst)
    sts.vcnt <= iee_pkg::CntW'(iee_pkg::StackDepth)) else $error("value count overrun");
  a_ocnt_range: assert property (@(posedge clk) disable iff (rst)
    sts.ocnt <= iee_pkg::CntW'(iee_pkg::StackDepth)) else $error("operator count overrun");
endmodule

// ----- bench/infix_expression_evaluator_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench: infix expression evaluator, directed table plus random expressions vs. predictor.
module infix_expression_evaluator_top_tb;

  typedef struct packed {
    logic [2:0]  act;
    logic [15:0] opnd;
    logic [1:0]  ocls;
    logic [3:0]  opc;
    logic [1:0]  smode;
  } word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] result;
    logic [1:0]  cls;
    logic        done;
  } res_t;

  typedef struct packed {
    word_t w;
    logic  known;
    res_t  r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pass_we = 1'b0;
  logic pass_wdata = 1'b0;

  iee_in_if in_ch (.clk(clk));
  iee_out_if out_ch (.clk(clk));

  infix_expression_evaluator_top u_top (
    .clk(clk), .rst(rst), .pass_we(pass_we), .pass_wdata(pass_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // evaluator state mirror
  logic [15:0] val_stk [iee_pkg::StackDepth];
  logic [3:0]  op_stk [iee_pkg::StackDepth];
  int unsigned val_cnt, op_cnt;
  logic [1:0]  run_cls;
  logic        force_static;
  logic [3:0]  sticky;
  logic        pass_r;

  res_t expected_q[$];
  row_t stim_q[$];
  int   errors, words_sent, results_seen, burst_left, zdiv_seen;

  function automatic int unsigned prec_lvl(logic [3:0] code);
    case (code)
      iee_pkg::OP_ORNOT: return 1;
      iee_pkg::OP_ADD, iee_pkg::OP_SUB: return 2;
      iee_pkg::OP_MUL, iee_pkg::OP_DIV, iee_pkg::OP_MOD: return 3;
      iee_pkg::OP_SHR, iee_pkg::OP_SHL: return 4;
      iee_pkg::OP_AND: return 5;
      iee_pkg::OP_XOR: return 6;
      iee_pkg::OP_OR: return 7;
      default: return 0;
    endcase
  endfunction

  function automatic bit reduce_top();
    logic [3:0]  op;
    logic [31:0] a, b, r;
    if (op_cnt == 0) begin
      sticky = iee_pkg::ST_OP_UNDER;
      return 0;
    end
    op_cnt--;
    op = op_stk[op_cnt];
    if (val_cnt < 2) begin
      sticky = iee_pkg::ST_VAL_UNDER;
      return 0;
    end
    if (op == iee_pkg::OP_PAREN) begin
      sticky = iee_pkg::ST_STRAY_LP;
      return 0;
    end
    b = val_stk[val_cnt-1];
    a = val_stk[val_cnt-2];
    val_cnt -= 2;
    case (op)
      iee_pkg::OP_ORNOT: r = a | (~b & 32'hFFFF);
      iee_pkg::OP_ADD: r = a + b;
      iee_pkg::OP_SUB: r = a - b;
      iee_pkg::OP_MUL: r = a * b;
      iee_pkg::OP_DIV, iee_pkg::OP_MOD: begin
        if (b == 0) begin
          if (pass_r) begin
            sticky = iee_pkg::ST_ZERO_DIV;
            return 0;
          end
          r = 0;
        end else begin
          r = (op == iee_pkg::OP_DIV) ? a / b : a % b;
        end
      end
      iee_pkg::OP_SHR: r = (b >= 16) ? 0 : a >> b;
      iee_pkg::OP_SHL: r = (b >= 16) ? 0 : a << b;
      iee_pkg::OP_AND: r = a & b;
      iee_pkg::OP_XOR: r = a ^ b;
      iee_pkg::OP_OR: r = a | b;
      default: r = 0;
    endcase
    val_stk[val_cnt] = r[15:0];
    val_cnt++;
    return 1;
  endfunction

  function automatic void push_oper(logic [3:0] code);
    if (op_cnt >= iee_pkg::StackDepth) sticky = iee_pkg::ST_OP_OVER;
    else begin
      op_stk[op_cnt] = code;
      op_cnt++;
    end
  endfunction

  function automatic bit paren_open();
    for (int i = 0; i < op_cnt; i++) if (op_stk[i] == iee_pkg::OP_PAREN) return 1;
    return 0;
  endfunction

  function automatic res_t eval_word(word_t w);
    res_t r;
    bit ok;
    logic [1:0] c;
    r = '0;
    ok = 1;
    if (w.act == iee_pkg::ACT_BEGIN) begin
      val_cnt = 0;
      op_cnt = 0;
      sticky = iee_pkg::ST_OK;
      force_static = (w.smode == iee_pkg::MODE_FORCE);
      run_cls = (w.smode == iee_pkg::MODE_RELOC) ? iee_pkg::CLS_RELOC : iee_pkg::CLS_STATIC;
    end else if (sticky == iee_pkg::ST_OK) begin
      case (w.act)
        iee_pkg::ACT_OPERAND: begin
          c = (w.ocls > iee_pkg::CLS_STATIC) ? iee_pkg::CLS_STATIC : w.ocls;
          if (c < run_cls) run_cls = c;
          if (val_cnt >= iee_pkg::StackDepth) sticky = iee_pkg::ST_VAL_OVER;
          else begin
            val_stk[val_cnt] = w.opnd;
            val_cnt++;
          end
        end
        iee_pkg::ACT_OPER: if (w.opc < 11) begin
          while (ok && op_cnt > 0 && prec_lvl(w.opc) <= prec_lvl(op_stk[op_cnt-1]))
            ok = reduce_top();
          if (ok) push_oper(w.opc);
        end
        iee_pkg::ACT_LPAREN: push_oper(iee_pkg::OP_PAREN);
        iee_pkg::ACT_RPAREN: begin
          if (!paren_open()) sticky = iee_pkg::ST_STRAY_RP;
          else begin
            while (ok && op_cnt > 0 && op_stk[op_cnt-1] != iee_pkg::OP_PAREN)
              ok = reduce_top();
            if (ok && op_cnt > 0) op_cnt--;
          end
        end
        iee_pkg::ACT_FINISH: begin
          while (ok && op_cnt > 0) ok = reduce_top();
          if (ok) begin
            if (val_cnt == 0) sticky = iee_pkg::ST_VAL_UNDER;
            else if (val_cnt != 1) sticky = iee_pkg::ST_LEFTOVER;
          end
        end
        default: ;
      endcase
    end
    r.status = sticky;
    r.cls = run_cls;
    if (w.act == iee_pkg::ACT_FINISH) begin
      r.done = 1'b1;
      if (sticky == iee_pkg::ST_OK) begin
        r.result = val_stk[0];
        if (force_static && run_cls != iee_pkg::CLS_UNRES) r.cls = iee_pkg::CLS_STATIC;
      end else begin
        r.cls = iee_pkg::CLS_UNRES;
      end
    end
    if (r.status == iee_pkg::ST_ZERO_DIV) zdiv_seen++;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_q.size() == 0) report_mismatch("result word with nothing expected");
      else begin
        e = expected_q.pop_front();
        if (out_ch.status !== e.status || out_ch.result !== e.result ||
            out_ch.result_class !== e.cls || out_ch.done_res !== e.done)
          report_mismatch($sformatf(
            "got st=%0d res=%h cls=%0d done=%0b exp st=%0d res=%h cls=%0d done=%0b",
            out_ch.status, out_ch.result, out_ch.result_class, out_ch.done_res,
            e.status, e.result, e.cls, e.done));
      end
    end
  end

  // receiver: run/stall pattern plus one long hold-off
  initial begin
    int hold_cnt, run_cnt;
    bit held, run_val;
    hold_cnt = 0;
    run_cnt = 0;
    held = 0;
    run_val = 0;
    out_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 200) begin
        held = 1;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        if (run_cnt == 0) begin
          run_val = !run_val;
          if (run_val) run_cnt = ($urandom_range(9) == 0) ? 200 : $urandom_range(25, 1);
          else run_cnt = $urandom_range(6, 1);
        end
        run_cnt--;
        out_ch.ready <= run_val;
      end
    end
  end

  task automatic send_row(input row_t row);
    res_t p;
    in_ch.valid <= 1'b1;
    in_ch.action <= row.w.act;
    in_ch.operand <= row.w.opnd;
    in_ch.operand_class <= row.w.ocls;
    in_ch.operator_code <= row.w.opc;
    in_ch.start_mode <= row.w.smode;
    do @(posedge clk); while (!in_ch.ready);
    p = eval_word(row.w);
    expected_q.push_back(row.known ? row.r : p);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(4) == 0) ? 60 : $urandom_range(20, 1);
    end
  endtask

  task automatic set_pass(input logic p);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    pass_we <= 1'b1;
    pass_wdata <= p;
    @(posedge clk);
    pass_we <= 1'b0;
    pass_r = p;
  endtask

  task automatic add_row(input logic [2:0] act, input logic [15:0] opnd, input logic [1:0] ocls,
                         input logic [3:0] opc, input logic [1:0] smode, input logic known = 0,
                         input res_t r = '0);
    row_t row;
    row.w = '{act, opnd, ocls, opc, smode};
    row.known = known;
    row.r = r;
    stim_q.push_back(row);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(3))
      0: return 16'($urandom_range(3));
      1: return 16'($urandom_range(18, 14));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic build_expr();
    int kind, nterms, depth;
    kind = $urandom_range(99);
    if (kind < 8) begin
      add_row(3'($urandom), 16'($urandom), 2'($urandom), 4'($urandom), 2'($urandom));
    end else if (kind < 12) begin
      add_row(iee_pkg::ACT_BEGIN, 0, 0, 0, 2'($urandom));
      repeat (17) add_row(($urandom_range(1)) ? iee_pkg::ACT_OPERAND : iee_pkg::ACT_LPAREN,
                          pick_value(), 2'($urandom), 0, 0);
      add_row(iee_pkg::ACT_FINISH, 0, 0, 0, 0);
    end else begin
      add_row(iee_pkg::ACT_BEGIN, 16'($urandom), 2'($urandom), 4'($urandom), 2'($urandom));
      nterms = $urandom_range(8, 1);
      depth = 0;
      for (int t = 0; t < nterms; t++) begin
        if (depth < 4 && $urandom_range(99) < 25) begin
          add_row(iee_pkg::ACT_LPAREN, 0, 0, 0, 0);
          depth++;
        end
        add_row(iee_pkg::ACT_OPERAND, pick_value(), 2'($urandom), 0, 0);
        while (depth > 0 && $urandom_range(99) < 30) begin
          add_row(iee_pkg::ACT_RPAREN, 0, 0, 0, 0);
          depth--;
        end
        if (t != nterms - 1)
          add_row(iee_pkg::ACT_OPER, 0, 0,
                  ($urandom_range(19) == 0) ? 4'($urandom) : 4'($urandom_range(10)), 0);
      end
      if ($urandom_range(19) == 0) depth = depth + $urandom_range(1) - 1;
      for (int d = 0; d < depth; d++) add_row(iee_pkg::ACT_RPAREN, 0, 0, 0, 0);
      add_row(iee_pkg::ACT_FINISH, 0, 0, 0, 0);
    end
  endtask

  initial begin
    int target;
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    zdiv_seen = 0;
    burst_left = 5;
    in_ch.valid = 1'b0;
    in_ch.action = iee_pkg::ACT_BEGIN;
    in_ch.operand = '0;
    in_ch.operand_class = '0;
    in_ch.operator_code = '0;
    in_ch.start_mode = '0;
    val_cnt = 0;
    op_cnt = 0;
    run_cls = iee_pkg::CLS_STATIC;
    force_static = 0;
    sticky = iee_pkg::ST_OK;
    pass_r = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_pass(1'b0);

    add_row(iee_pkg::ACT_BEGIN, 0, 0, 0, 0, 1,
            '{iee_pkg::ST_OK, 16'h0, iee_pkg::CLS_STATIC, 1'b0});
    add_row(iee_pkg::ACT_OPERAND, 16'hFFFF, iee_pkg::CLS_STATIC, 0, 0, 1,
            '{iee_pkg::ST_OK, 16'h0, iee_pkg::CLS_STATIC, 1'b0});
    add_row(iee_pkg::ACT_OPER, 0, 0, iee_pkg::OP_ADD, 0);
    add_row(iee_pkg::ACT_OPERAND, 16'h0001, iee_pkg::CLS_STATIC, 0, 0);
    add_row(iee_pkg::ACT_FINISH, 0, 0, 0, 0, 1,
            '{iee_pkg::ST_OK, 16'h0, iee_pkg::CLS_STATIC, 1'b1});
    add_row(iee_pkg::ACT_BEGIN, 0, 0, 0, iee_pkg::MODE_RELOC, 1,
            '{iee_pkg::ST_OK, 16'h0, iee_pkg::CLS_RELOC, 1'b0});
    add_row(iee_pkg::ACT_RPAREN, 0, 0, 0, 0, 1,
            '{iee_pkg::ST_STRAY_RP, 16'h0, iee_pkg::CLS_RELOC, 1'b0});
    add_row(iee_pkg::ACT_FINISH, 0, 0, 0, 0, 1,
            '{iee_pkg::ST_STRAY_RP, 16'h0, iee_pkg::CLS_UNRES, 1'b1});
    add_row(iee_pkg::ACT_BEGIN, 0, 0, 0, 0);
    add_row(iee_pkg::ACT_FINISH, 0, 0, 0, 0, 1,
            '{iee_pkg::ST_VAL_UNDER, 16'h0, iee_pkg::CLS_UNRES, 1'b1});
    add_row(iee_pkg::ACT_BEGIN, 0, 0, 0, iee_pkg::MODE_FORCE);
    add_row(iee_pkg::ACT_OPERAND, 16'd5, 2'd3, 0, 0);
    add_row(iee_pkg::ACT_OPER, 0, 0, iee_pkg::OP_DIV, 0);
    add_row(iee_pkg::ACT_OPERAND, 16'd0, iee_pkg::CLS_RELOC, 0, 0);
    add_row(iee_pkg::ACT_OPER, 0, 0, iee_pkg::OP_MOD, 0);
    add_row(iee_pkg::ACT_OPERAND, 16'd0, iee_pkg::CLS_STATIC, 0, 0);
    add_row(iee_pkg::ACT_OPER, 0, 0, iee_pkg::OP_SUB, 0);
    add_row(iee_pkg::ACT_OPERAND, 16'd7, iee_pkg::CLS_STATIC, 0, 0);
    add_row(iee_pkg::ACT_FINISH, 0, 0, 0, 0);
    add_row(iee_pkg::ACT_BEGIN, 0, 0, 0, 2'd3);
    add_row(iee_pkg::ACT_OPERAND, 16'hF0F0, iee_pkg::CLS_UNRES, 0, 0);
    add_row(iee_pkg::ACT_OPER, 0, 0, iee_pkg::OP_ORNOT, 0);
    add_row(iee_pkg::ACT_LPAREN, 0, 0, 0, 0);
    add_row(iee_pkg::ACT_OPERAND, 16'h00FF, iee_pkg::CLS_STATIC, 0, 0);
    add_row(iee_pkg::ACT_OPER, 0, 0, iee_pkg::OP_SHL, 0);
    add_row(iee_pkg::ACT_OPERAND, 16'd20, iee_pkg::CLS_STATIC, 0, 0);
    add_row(iee_pkg::ACT_OPER, 0, 0, iee_pkg::OP_OR, 0);
    add_row(iee_pkg::ACT_OPERAND, 16'h1234, iee_pkg::CLS_STATIC, 0, 0);
    add_row(iee_pkg::ACT_OPER, 0, 0, 4'd12, 0);
    add_row(3'd6, 16'hFFFF, 2'd3, 4'hF, 2'd3);
    add_row(iee_pkg::ACT_OPER, 0, 0, iee_pkg::OP_AND, 0);
    add_row(iee_pkg::ACT_OPERAND, 16'h0FF0, iee_pkg::CLS_STATIC, 0, 0);
    add_row(iee_pkg::ACT_RPAREN, 0, 0, 0, 0);
    add_row(iee_pkg::ACT_OPER, 0, 0, iee_pkg::OP_XOR, 0);
    add_row(iee_pkg::ACT_OPERAND, 16'd3, iee_pkg::CLS_STATIC, 0, 0);
    add_row(iee_pkg::ACT_OPER, 0, 0, iee_pkg::OP_MUL, 0);
    add_row(iee_pkg::ACT_OPERAND, 16'd9, iee_pkg::CLS_STATIC, 0, 0);
    add_row(iee_pkg::ACT_OPER, 0, 0, iee_pkg::OP_SHR, 0);
    add_row(iee_pkg::ACT_OPERAND, 16'd16, iee_pkg::CLS_STATIC, 0, 0);
    add_row(iee_pkg::ACT_FINISH, 0, 0, 0, 0);
    while (stim_q.size() != 0) send_row(stim_q.pop_front());

    for (int ph = 0; ph < 6; ph++) begin
      set_pass(ph[0] ^ 1'b1);
      target = words_sent + 125;
      while (words_sent < target) begin
        build_expr();
        while (stim_q.size() != 0) send_row(stim_q.pop_front());
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d words over both pass settings, checked %0d results.",
             words_sent, results_seen);
    $display("Zero-divide errors seen: %0d, mismatches: %0d.", zdiv_seen, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TIMEOUT with %0d results outstanding", expected_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule
